// File: rtl/mer_pkg.sv
// Shared constants and helpers for the midpoint ellipse rasterizer.
package mer_pkg;

    // Default coordinate width in bits
    localparam int COORD_WIDTH_DEF = 10;

    // Width of the register index on the configuration port
    localparam int CFG_INDEX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_X = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_Y = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RADIUS_X = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RADIUS_Y = 2'd3;

    // Width of the decision variable for a given coordinate width
    function automatic int dec_width(input int cw);
        return ((4 * cw + 8) > 64) ? 64 : (4 * cw + 8);
    endfunction

endpackage

// File: rtl/midpoint_ellipse_rasterizer_core.sv
// Midpoint ellipse rasterizer: one shared multiplier under a small sequencer.
//
// channel  | direction | handshake            | payload
// ---------+-----------+----------------------+-------------------------------------------
// cfg      | in        | cfg_we               | cfg_index, cfg_data
// in       | in        | in_valid / in_stall  | restart
// out      | out       | out_valid / out_stall| point_x, point_y, last_of_step, done_res
//
// The single multiplier sets the pace of an item: each step issues its squares and
// products one per cycle. in_stall stays high from acceptance until the sequencer
// is idle again: after the decision update of a point item, once a done item is
// loaded, or after the check on a finished ellipse. Reset is asynchronous, active
// low, and leaves the ellipse finished. out_stall only holds the output register
// and the sequencer.
module midpoint_ellipse_rasterizer_core
    import mer_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [CFG_INDEX_W-1:0]        cfg_index,
    input  logic [COORD_WIDTH-1:0]        cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          restart,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [COORD_WIDTH+1:0] point_x,
    output logic signed [COORD_WIDTH+1:0] point_y,
    output logic                          last_of_step,
    output logic                          done_res
);

    localparam int RAD_W = COORD_WIDTH - 1;
    localparam int SQ_W  = 2 * RAD_W;
    localparam int Y_W   = COORD_WIDTH + 1;
    localparam int OUT_W = COORD_WIDTH + 2;
    localparam int MA_W  = 2 * COORD_WIDTH + 2;
    localparam int MB_W  = 2 * COORD_WIDTH - 1;
    localparam int PR_W  = MA_W + MB_W + 1;
    localparam int DEC_W = dec_width(COORD_WIDTH);
    localparam int EXT_W = (PR_W > DEC_W) ? PR_W : DEC_W;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SQX,
        S_SQY,
        S_SQW,
        S_RST,
        S_CHK0,
        S_CHK1,
        S_CHK2,
        S_SET1,
        S_SET2,
        S_SET3,
        S_SET4,
        S_SET5,
        S_DCHK,
        S_EMIT,
        S_EMITD,
        S_UPD0,
        S_UPD1,
        S_UPD2
    } state_t;

    state_t                    state_reg;
    logic                      restart_reg;
    logic [COORD_WIDTH-1:0]    cx_reg;
    logic [COORD_WIDTH-1:0]    cy_reg;
    logic [RAD_W-1:0]          rx_reg;
    logic [RAD_W-1:0]          ry_reg;
    logic [SQ_W-1:0]           rx2_reg;
    logic [SQ_W-1:0]           ry2_reg;
    logic [COORD_WIDTH-1:0]    x_reg;
    logic signed [Y_W-1:0]     y_reg;
    logic                      r2_reg;
    logic                      finished_reg;
    logic signed [DEC_W-1:0]   decision_reg;
    logic signed [DEC_W-1:0]   acc_reg;
    logic signed [DEC_W-1:0]   prod_reg;
    logic signed [DEC_W-1:0]   prod_next;
    logic [1:0]                pt_idx_reg;
    logic                      upd_x_reg;
    logic                      upd_y_reg;
    logic                      out_valid_reg;
    logic signed [OUT_W-1:0]   point_x_reg;
    logic signed [OUT_W-1:0]   point_y_reg;
    logic                      last_reg;
    logic                      done_reg;

    logic [MA_W-1:0]           mul_a;
    logic signed [MB_W-1:0]    mul_b;
    logic signed [PR_W-1:0]    mul_full;
    logic [COORD_WIDTH:0]      tx;
    logic signed [Y_W:0]       ym1;
    logic [Y_W-1:0]            ym1_abs;
    logic                      dec_neg;
    logic                      dec_pos;
    logic [COORD_WIDTH-1:0]    x_step;
    logic signed [Y_W-1:0]     y_step;
    logic                      ux_step;
    logic                      uy_step;
    logic                      stay;
    logic                      out_free;
    logic                      out_load;
    logic signed [OUT_W-1:0]   cx_ext;
    logic signed [OUT_W-1:0]   cy_ext;
    logic signed [OUT_W-1:0]   x_ext;
    logic signed [OUT_W-1:0]   y_ext;
    logic signed [OUT_W-1:0]   pt_x;
    logic signed [OUT_W-1:0]   pt_y;
    logic signed [DEC_W-1:0]   rx2_ext;
    logic signed [DEC_W-1:0]   ry2_ext;

    // Ports
    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign point_x      = point_x_reg;
    assign point_y      = point_y_reg;
    assign last_of_step = last_reg;
    assign done_res     = done_reg;
    assign out_free     = !out_valid_reg || !out_stall;
    assign out_load     = ((state_reg == S_EMIT) || (state_reg == S_EMITD)) && out_free;

    // Helper terms for region two set-up
    assign tx      = {x_reg, 1'b1};
    assign ym1     = {y_reg[Y_W-1], y_reg} - (Y_W + 1)'(1);
    assign ym1_abs = ym1[Y_W] ? Y_W'(-ym1) : ym1[Y_W-1:0];

    // Region one exit test: ry^2 * x held in acc, rx^2 * y in the product
    assign stay = !y_reg[Y_W-1] && (acc_reg < prod_reg);

    assign rx2_ext = $signed(DEC_W'(rx2_reg));
    assign ry2_ext = $signed(DEC_W'(ry2_reg));

    // Offset move chosen by the decision sign
    always_comb
    begin
        dec_neg = decision_reg[DEC_W-1];
        dec_pos = !dec_neg && (decision_reg != '0);
        if (!r2_reg)
        begin
            x_step  = x_reg + 1'b1;
            y_step  = dec_neg ? y_reg : y_reg - Y_W'(1);
            ux_step = 1'b1;
            uy_step = !dec_neg;
        end
        else
        begin
            x_step  = dec_pos ? x_reg : x_reg + 1'b1;
            y_step  = y_reg - Y_W'(1);
            ux_step = !dec_pos;
            uy_step = 1'b1;
        end
    end

    // Select multiplier operands for each sequencer step
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_SQX:
            begin
                mul_a = MA_W'(rx_reg);
                mul_b = $signed(MB_W'(rx_reg));
            end
            S_SQY:
            begin
                mul_a = MA_W'(ry_reg);
                mul_b = $signed(MB_W'(ry_reg));
            end
            S_SQW:
            begin
                mul_a = MA_W'(rx2_reg);
                mul_b = $signed(MB_W'(ry_reg));
            end
            S_CHK0:
            begin
                mul_a = MA_W'(ry2_reg);
                mul_b = $signed(MB_W'(x_reg));
            end
            S_CHK1:
            begin
                mul_a = MA_W'(rx2_reg);
                mul_b = MB_W'(y_reg);
            end
            S_CHK2:
            begin
                mul_a = MA_W'(tx);
                mul_b = $signed(MB_W'(tx));
            end
            S_SET1:
            begin
                mul_a = prod_reg[MA_W-1:0];
                mul_b = $signed(MB_W'(ry2_reg));
            end
            S_SET2:
            begin
                mul_a = MA_W'(ym1_abs);
                mul_b = $signed(MB_W'(ym1_abs));
            end
            S_SET3:
            begin
                mul_a = prod_reg[MA_W-1:0];
                mul_b = $signed(MB_W'(rx2_reg));
            end
            S_SET4:
            begin
                mul_a = MA_W'(rx2_reg);
                mul_b = $signed(MB_W'(ry2_reg));
            end
            S_UPD0:
            begin
                mul_a = MA_W'(ry2_reg);
                mul_b = $signed(MB_W'(x_step));
            end
            S_UPD1:
            begin
                mul_a = MA_W'(rx2_reg);
                mul_b = MB_W'(y_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Shared multiplier, wrapped to the decision width
    assign mul_full  = $signed({1'b0, mul_a}) * mul_b;
    assign prod_next = DEC_W'(EXT_W'(mul_full));

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    // Symmetric point for the current emit slot
    always_comb
    begin
        cx_ext = $signed(OUT_W'(cx_reg));
        cy_ext = $signed(OUT_W'(cy_reg));
        x_ext  = $signed(OUT_W'(x_reg));
        y_ext  = OUT_W'(y_reg);
        pt_x   = (pt_idx_reg == 2'd1 || pt_idx_reg == 2'd2) ? cx_ext - x_ext
                                                             : cx_ext + x_ext;
        pt_y   = pt_idx_reg[1] ? cy_ext - y_ext : cy_ext + y_ext;
    end

    // Sequencer, walk state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            restart_reg   <= 1'b0;
            cx_reg        <= '0;
            cy_reg        <= '0;
            rx_reg        <= '0;
            ry_reg        <= '0;
            rx2_reg       <= '0;
            ry2_reg       <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            r2_reg        <= 1'b0;
            finished_reg  <= 1'b1;
            decision_reg  <= '0;
            acc_reg       <= '0;
            pt_idx_reg    <= '0;
            upd_x_reg     <= 1'b0;
            upd_y_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            point_x_reg   <= '0;
            point_y_reg   <= '0;
            last_reg      <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            // Configuration writes
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_CENTER_X: cx_reg <= cfg_data;
                    REG_CENTER_Y: cy_reg <= cfg_data;
                    REG_RADIUS_X: rx_reg <= cfg_data[RAD_W-1:0];
                    REG_RADIUS_Y: ry_reg <= cfg_data[RAD_W-1:0];
                    default:      ;
                endcase
            end

            // Drop the output item once taken and nothing new is loaded
            if (out_valid_reg && !out_stall && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        restart_reg <= restart;
                        state_reg   <= S_SQX;
                    end
                end
                S_SQX:
                begin
                    state_reg <= S_SQY;
                end
                S_SQY:
                begin
                    rx2_reg   <= prod_reg[SQ_W-1:0];
                    state_reg <= S_SQW;
                end
                S_SQW:
                begin
                    ry2_reg   <= prod_reg[SQ_W-1:0];
                    state_reg <= restart_reg ? S_RST : S_CHK0;
                end
                // Start of region one at (0, ry)
                S_RST:
                begin
                    decision_reg <= (ry2_ext <<< 2) + rx2_ext - (prod_reg <<< 2);
                    x_reg        <= '0;
                    y_reg        <= $signed(Y_W'(ry_reg));
                    r2_reg       <= 1'b0;
                    finished_reg <= 1'b0;
                    state_reg    <= S_CHK0;
                end
                S_CHK0:
                begin
                    if (finished_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (r2_reg)
                    begin
                        state_reg <= S_DCHK;
                    end
                    else
                    begin
                        state_reg <= S_CHK1;
                    end
                end
                S_CHK1:
                begin
                    acc_reg   <= prod_reg;
                    state_reg <= S_CHK2;
                end
                S_CHK2:
                begin
                    if (stay)
                    begin
                        pt_idx_reg <= '0;
                        state_reg  <= S_EMIT;
                    end
                    else
                    begin
                        r2_reg    <= 1'b1;
                        state_reg <= S_SET1;
                    end
                end
                // Region two decision set-up
                S_SET1:
                begin
                    state_reg <= S_SET2;
                end
                S_SET2:
                begin
                    acc_reg   <= prod_reg;
                    state_reg <= S_SET3;
                end
                S_SET3:
                begin
                    state_reg <= S_SET4;
                end
                S_SET4:
                begin
                    acc_reg   <= acc_reg + (prod_reg <<< 2);
                    state_reg <= S_SET5;
                end
                S_SET5:
                begin
                    decision_reg <= acc_reg - (prod_reg <<< 2);
                    state_reg    <= S_DCHK;
                end
                S_DCHK:
                begin
                    if (r2_reg && y_reg[Y_W-1])
                    begin
                        state_reg <= S_EMITD;
                    end
                    else
                    begin
                        pt_idx_reg <= '0;
                        state_reg  <= S_EMIT;
                    end
                end
                // Emit the four symmetric points
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        point_x_reg   <= pt_x;
                        point_y_reg   <= pt_y;
                        last_reg      <= (pt_idx_reg == 2'd3);
                        done_reg      <= 1'b0;
                        pt_idx_reg    <= pt_idx_reg + 2'd1;
                        if (pt_idx_reg == 2'd3)
                        begin
                            state_reg <= S_UPD0;
                        end
                    end
                end
                S_EMITD:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        point_x_reg   <= '0;
                        point_y_reg   <= '0;
                        last_reg      <= 1'b1;
                        done_reg      <= 1'b1;
                        finished_reg  <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                // Advance the offset and update the decision
                S_UPD0:
                begin
                    x_reg     <= x_step;
                    y_reg     <= y_step;
                    upd_x_reg <= ux_step;
                    upd_y_reg <= uy_step;
                    state_reg <= S_UPD1;
                end
                S_UPD1:
                begin
                    acc_reg   <= decision_reg
                                 + ((r2_reg ? rx2_ext : ry2_ext) <<< 2)
                                 + (upd_x_reg ? (prod_reg <<< 3) : '0);
                    state_reg <= S_UPD2;
                end
                S_UPD2:
                begin
                    decision_reg <= acc_reg - (upd_y_reg ? (prod_reg <<< 3) : '0);
                    state_reg    <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: rtl/mer_checker.sv
// Port-level checks for the midpoint ellipse rasterizer, bound to the top level.
module mer_checker
    import mer_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic signed [COORD_WIDTH+1:0] point_x,
    input logic signed [COORD_WIDTH+1:0] point_y,
    input logic                          last_of_step,
    input logic                          done_res
);

    // Busy right after taking an item
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("block ready in the cycle after accepting an item");

    // Done item carries zero points and closes the step
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> last_of_step && point_x == '0 && point_y == '0)
        else $error("done item with point data or without last flag");

    // Points of one step follow back to back while the step stays busy
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_of_step |=> out_valid && in_stall)
        else $error("gap or new item inside the points of one step");

    // Stalled output item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(point_x) && $stable(point_y)
            && $stable(last_of_step) && $stable(done_res))
        else $error("stalled output item changed");

endmodule

bind midpoint_ellipse_rasterizer_core mer_checker #(
    .COORD_WIDTH(COORD_WIDTH)
) u_mer_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .point_x      (point_x),
    .point_y      (point_y),
    .last_of_step (last_of_step),
    .done_res     (done_res)
);

// File: tb/midpoint_ellipse_rasterizer_core_tb.sv
// Self-checking testbench for the midpoint ellipse rasterizer core.
module midpoint_ellipse_rasterizer_core_tb;
    import mer_pkg::*;

    localparam int CW           = COORD_WIDTH_DEF;
    localparam int DW           = dec_width(CW);
    localparam int SETTLE       = 40;
    localparam int LONG_HOLD    = 300;
    localparam int STUCK_LIMIT  = 3000;
    localparam int RANDOM_ITEMS = 130;

    typedef struct packed {
        logic signed [CW+1:0] px;
        logic signed [CW+1:0] py;
        logic                 last;
        logic                 fin;
    } ellipse_pixel_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0]     cfg_index = '0;
    logic [CW-1:0]              cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic                       restart = 1'b0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic signed [CW+1:0]       point_x;
    logic signed [CW+1:0]       point_y;
    logic                       last_of_step;
    logic                       done_res;

    // Stimulus and scoreboard storage
    logic                       step_q[$];
    ellipse_pixel_t             pending_pixels[$];
    int                         errors = 0;
    int unsigned                queued = 0;
    int unsigned                stuck_cycles = 0;
    int unsigned                send_gap = 0;
    int unsigned                hold_left = 0;
    logic                       quiet = 1'b0;
    logic                       long_hold_req = 1'b0;
    logic                       long_hold_done = 1'b0;

    // Predictor copy of registers and walk state
    logic [CW-1:0]              reg_cx = '0;
    logic [CW-1:0]              reg_cy = '0;
    logic [CW-2:0]              reg_rx = '0;
    logic [CW-2:0]              reg_ry = '0;
    logic [CW-1:0]              walk_x = '0;
    logic signed [CW:0]         walk_y = '0;
    logic                       walk_r2 = 1'b0;
    logic [DW-1:0]              walk_d = '0;
    logic                       walk_done = 1'b1;

    midpoint_ellipse_rasterizer_core #(
        .COORD_WIDTH(CW)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .restart      (restart),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .point_x      (point_x),
        .point_y      (point_y),
        .last_of_step (last_of_step),
        .done_res     (done_res)
    );

    always #1 clk = ~clk;

    // Mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic logic [63:0] sext_y(input logic signed [CW:0] v);
        return {{(64-CW-1){v[CW]}}, v};
    endfunction

    // Advance the predicted walk by one item and queue the pixels it emits
    task automatic walk_ellipse_step(input logic rs);
        logic [63:0] rx2, ry2, xv, yv, ym1, tx, p, cx, cy;
        logic        stay, neg, pos;
        ellipse_pixel_t pix;
        rx2 = 64'(reg_rx) * 64'(reg_rx);
        ry2 = 64'(reg_ry) * 64'(reg_ry);
        cx  = 64'(reg_cx);
        cy  = 64'(reg_cy);
        if (rs)
        begin
            walk_x    = '0;
            walk_y    = $signed({2'b00, reg_ry});
            walk_r2   = 1'b0;
            walk_d    = DW'(64'd4 * ry2 + rx2 - 64'd4 * rx2 * 64'(reg_ry));
            walk_done = 1'b0;
        end
        if (walk_done)
            return;

        // Leave region one once the slope passes -1
        if (!walk_r2)
        begin
            stay = !walk_y[CW] && (ry2 * 64'(walk_x) < rx2 * sext_y(walk_y));
            if (!stay)
            begin
                walk_r2 = 1'b1;
                tx      = 64'd2 * 64'(walk_x) + 64'd1;
                ym1     = sext_y(walk_y) - 64'd1;
                walk_d  = DW'(ry2 * tx * tx + 64'd4 * rx2 * ym1 * ym1
                              - 64'd4 * rx2 * ry2);
            end
        end

        // Close the ellipse once y drops below zero
        if (walk_r2 && walk_y[CW])
        begin
            walk_done = 1'b1;
            pix = '{px: '0, py: '0, last: 1'b1, fin: 1'b1};
            pending_pixels.push_back(pix);
            return;
        end

        // Emit the four mirrored pixels
        xv = 64'(walk_x);
        yv = sext_y(walk_y);
        pix = '{px: (CW+2)'(cx + xv), py: (CW+2)'(cy + yv), last: 1'b0, fin: 1'b0};
        pending_pixels.push_back(pix);
        pix.px = (CW+2)'(cx - xv);
        pending_pixels.push_back(pix);
        pix.py = (CW+2)'(cy - yv);
        pending_pixels.push_back(pix);
        pix.px   = (CW+2)'(cx + xv);
        pix.last = 1'b1;
        pending_pixels.push_back(pix);

        // Update the decision variable and the offset
        p = 64'(walk_d);
        if (!walk_r2)
        begin
            neg    = walk_d[DW-1];
            walk_x = walk_x + 1'b1;
            xv     = 64'(walk_x);
            if (neg)
                p = p + 64'd8 * ry2 * xv + 64'd4 * ry2;
            else
            begin
                walk_y = walk_y - (CW+1)'(1);
                yv     = sext_y(walk_y);
                p = p + 64'd8 * ry2 * xv + 64'd4 * ry2 - 64'd8 * rx2 * yv;
            end
        end
        else
        begin
            pos    = !walk_d[DW-1] && (walk_d != '0);
            walk_y = walk_y - (CW+1)'(1);
            yv     = sext_y(walk_y);
            if (pos)
                p = p + 64'd4 * rx2 - 64'd8 * rx2 * yv;
            else
            begin
                walk_x = walk_x + 1'b1;
                xv     = 64'(walk_x);
                p = p + 64'd4 * rx2 + 64'd8 * ry2 * xv - 64'd8 * rx2 * yv;
            end
        end
        walk_d = p[DW-1:0];
    endtask

    // Driver: offer queued items, with random gaps after each one
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (send_gap != 0)
            begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (step_q.size() != 0)
            begin
                in_valid <= 1'b1;
                restart  <= step_q.pop_front();
                send_gap <= quiet ? 0 : pick_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: random stall runs, one long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (long_hold_req && !long_hold_done)
        begin
            out_stall      <= 1'b1;
            hold_left      <= LONG_HOLD;
            long_hold_done <= 1'b1;
        end
        else if (quiet)
            out_stall <= 1'b0;
        else
        begin
            out_stall <= ($urandom_range(99) < 30);
            hold_left <= pick_gap();
        end
    end

    // Monitor: track registers, check results, predict accepted items
    always @(posedge clk)
    begin
        ellipse_pixel_t want;
        if (rst_n)
        begin
            if (cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
                stuck_cycles <= 0;
            else
                stuck_cycles <= stuck_cycles + 1;

            if (cfg_we)
            begin
                case (cfg_index)
                    REG_CENTER_X: reg_cx = cfg_data;
                    REG_CENTER_Y: reg_cy = cfg_data;
                    REG_RADIUS_X: reg_rx = cfg_data[CW-2:0];
                    REG_RADIUS_Y: reg_ry = cfg_data[CW-2:0];
                    default: ;
                endcase
            end

            if (out_valid && !out_stall)
            begin
                if (pending_pixels.size() == 0)
                begin
                    $error("unexpected result: point_x %0d point_y %0d", point_x, point_y);
                    errors++;
                end
                else
                begin
                    want = pending_pixels.pop_front();
                    if (point_x !== want.px)
                    begin
                        $error("point_x: expected %0d, got %0d", want.px, point_x);
                        errors++;
                    end
                    if (point_y !== want.py)
                    begin
                        $error("point_y: expected %0d, got %0d", want.py, point_y);
                        errors++;
                    end
                    if (last_of_step !== want.last)
                    begin
                        $error("last_of_step: expected %0b, got %0b", want.last, last_of_step);
                        errors++;
                    end
                    if (done_res !== want.fin)
                    begin
                        $error("done_res: expected %0b, got %0b", want.fin, done_res);
                        errors++;
                    end
                end
            end

            if (in_valid && !in_stall)
                walk_ellipse_step(restart);
        end
    end

    // Hold until all items are sent, all results are in and the block is quiet
    task automatic wait_drained();
        do
            @(negedge clk);
        while (step_q.size() != 0 || in_valid || pending_pixels.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CW-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_regs(input logic [CW-1:0] cx, input logic [CW-1:0] cy,
                            input logic [CW-1:0] rx, input logic [CW-1:0] ry);
        wait_drained();
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_RADIUS_X, rx);
        write_reg(REG_RADIUS_Y, ry);
        @(negedge clk);
    endtask

    function automatic logic [CW-1:0] pick_radius();
        int unsigned r;
        r = $urandom_range(99);
        case (r % 4)
            0: if (r < 8) return '0;
            1: if (r < 8) return 10'h1FF;
            2: if (r < 8) return 10'h3FF;
            3: if (r < 8) return 10'h200;
            default: ;
        endcase
        if (r < 15)
            return CW'($urandom);
        return {1'($urandom_range(1)), (CW-1)'($urandom_range(12))};
    endfunction

    function automatic logic [CW-1:0] pick_center();
        if ($urandom_range(99) < 10)
            return $urandom_range(1) ? '1 : '0;
        return CW'($urandom_range(1023));
    endfunction

    // One random setting: a restart, then mostly advances with stray restarts
    task automatic random_phase();
        int unsigned n;
        set_regs(pick_center(), pick_center(), pick_radius(), pick_radius());
        n = $urandom_range(30, 8);
        step_q.push_back(1'b1);
        repeat (n) step_q.push_back($urandom_range(99) < 7);
        queued += n + 1;
    endtask

    initial
    begin : stimulus
        int          phase;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Advance after reset, then a zero-size ellipse to its end and beyond
        step_q = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0};

        // Largest radii and centers, upper register bits dropped
        set_regs(10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF);
        step_q = '{1'b1, 1'b0, 1'b0};

        // Flat ellipse at the origin, points go negative
        set_regs(10'd0, 10'd0, 10'd511, 10'd1);
        step_q = '{1'b1, 1'b0, 1'b0};

        // Small ellipse: restart mid-walk, then run through to done
        set_regs(10'd700, 10'd5, 10'd3, 10'd2);
        step_q = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0,
                   1'b0, 1'b0, 1'b0, 1'b0};

        // Random settings until enough items are queued
        phase = 0;
        while (queued < RANDOM_ITEMS)
        begin
            quiet = (phase == 3);
            if (phase == 1)
                long_hold_req = 1'b1;
            random_phase();
            phase++;
        end

        wait_drained();
        if (pending_pixels.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_pixels.size());
            errors++;
        end
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog: end the run when nothing moves for too long
    initial
    begin : watchdog
        @(posedge rst_n);
        while (stuck_cycles < STUCK_LIMIT)
            @(posedge clk);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
